// File: design/psf_pkg.sv
// Shared constants, codes and helpers for the polyline step follower.
package psf_pkg;

  localparam int MAX_POINTS = 256;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int LEN_W      = DIFF_W;
  localparam int STEP_W     = 23;
  localparam int REP_W      = 23;
  localparam int TOT_W      = LEN_W + CNT_W;
  localparam int MOVED_W    = 31;
  localparam int PROD_W     = DIFF_W + STEP_W;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int DIV_STEPS  = PROD_W;
  localparam int ITER_W     = $clog2(DIV_STEPS + 1);
  localparam int ENTRY_W    = 2 * COORD_W;

  localparam logic [MOVED_W-1:0] MOVED_MAX = {MOVED_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_ADVANCE = 2'd2,
    ACT_SET     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STS_FULL_STEP = 3'd0,
    STS_END       = 3'd1,
    STS_NO_MOVE   = 3'd2,
    STS_SINGLE    = 3'd3,
    STS_DONE      = 3'd4,
    STS_LIST_FULL = 3'd5,
    STS_EMPTY_SET = 3'd6
  } status_e;

  // Register index of the repulsion distance on the configuration port
  localparam logic REG_REPULSION = 1'b0;

  // Magnitude of a signed coordinate difference
  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  // Difference b - a of two coordinates, one bit wider
  function automatic logic signed [DIFF_W-1:0] cdiff(input logic [COORD_W-1:0] b,
                                                     input logic [COORD_W-1:0] a);
    cdiff = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
  endfunction

endpackage

// File: design/psf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/polyline_step_follower.sv
// Top level: waypoint ring in RAM, segment walker with serial sqrt and divider.
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tuser: action; tdata: point_x, point_z, step_length
//  m_axis   | out       | tuser: status; tdata: pos_x, pos_z, moved, points_left
//  apb      | in/out    | register 0: repel distance (23 bits)
//
//  Clear, append, set position on zero or one waypoint and an advance with no
//  move go straight to the result state; set position on a longer list and an
//  advance over a single waypoint pass through one compare or read state first.
//  A longer advance examines segments in turn (one RAM read, two squares, a
//  25-step square root, one compare), then runs two 48-step dividers for the
//  segment it lands in; the number of segments walked sets the time.
//  Reset clears the list (no clearing pass); RAM contents stay undefined.
//  A finished result waits in the output register while the next request
//  is taken; the walker stalls at its end until that register frees up.
module polyline_step_follower (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // point_x[23:0], point_z[47:24], step_length[70:48]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // pos_x[23:0], pos_z[47:24], moved[78:48],
                                     // points_left[87:79]
  output logic [2:0]  m_axis_tuser,  // status[2:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'b0000_0000_0000_0001,
    S_SETCMP = 16'b0000_0000_0000_0010,
    S_SINGLE = 16'b0000_0000_0000_0100,
    S_LDA    = 16'b0000_0000_0000_1000,
    S_LDB    = 16'b0000_0000_0001_0000,
    S_DIFF   = 16'b0000_0000_0010_0000,
    S_SQX    = 16'b0000_0000_0100_0000,
    S_SQZ    = 16'b0000_0000_1000_0000,
    S_SQRT   = 16'b0000_0001_0000_0000,
    S_CHK    = 16'b0000_0010_0000_0000,
    S_MULX   = 16'b0000_0100_0000_0000,
    S_DIVX   = 16'b0000_1000_0000_0000,
    S_MULZ   = 16'b0001_0000_0000_0000,
    S_DIVZ   = 16'b0010_0000_0000_0000,
    S_FIN    = 16'b0100_0000_0000_0000,
    S_DONE   = 16'b1000_0000_0000_0000
  } state_e;

  localparam int CW = psf_pkg::COORD_W;

  state_e state_q, state_d;

  // Control state
  logic [psf_pkg::ADDR_W-1:0] head_q;
  logic [psf_pkg::CNT_W-1:0]  count_q;
  logic [psf_pkg::CNT_W-1:0]  seg_q;
  logic [psf_pkg::ITER_W-1:0] iter_q;
  logic [psf_pkg::REP_W-1:0]  rep_q;
  logic                       m_valid_q;

  // Datapath registers
  logic [CW-1:0]                  in_x_q, in_z_q;
  logic [psf_pkg::STEP_W-1:0]     step_q;
  logic [CW-1:0]                  ax_q, az_q, bx_q, bz_q;
  logic [psf_pkg::DIFF_W-1:0]     magx_q, magz_q;
  logic                           negx_q, negz_q;
  logic [psf_pkg::SQ_W-1:0]       sq_q, sq_n_q, sq_res_q, sq_bit_q;
  logic [psf_pkg::LEN_W-1:0]      len_q;
  logic [psf_pkg::TOT_W-1:0]      total_q;
  logic [psf_pkg::STEP_W-1:0]     r_q;
  logic [psf_pkg::PROD_W-1:0]     div_n_q;
  logic [psf_pkg::LEN_W-1:0]      div_rem_q;
  logic [psf_pkg::DIFF_W-1:0]     div_quo_q, ox_q;
  logic [CW-1:0]                  res_x_q, res_z_q;
  logic [psf_pkg::MOVED_W-1:0]    res_moved_q;
  psf_pkg::status_e               res_status_q;
  logic [87:0]                    m_data_q;
  logic [2:0]                     m_user_q;

  // Memory port
  logic                         mem_we;
  logic [psf_pkg::ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [psf_pkg::ENTRY_W-1:0]  mem_wdata, mem_rdata;
  logic [CW-1:0]                rd_x, rd_z;

  psf_ram #(
    .WIDTH (psf_pkg::ENTRY_W),
    .DEPTH (psf_pkg::MAX_POINTS)
  ) u_way_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_x = mem_rdata[CW-1:0];
  assign rd_z = mem_rdata[psf_pkg::ENTRY_W-1:CW];

  // Ring slot of list position k
  function automatic logic [psf_pkg::ADDR_W-1:0] slot(input logic [psf_pkg::ADDR_W-1:0] h,
                                                      input logic [psf_pkg::CNT_W-1:0] k);
    logic [psf_pkg::CNT_W-1:0] s;
    s = {1'b0, h} + k;
    slot = s[psf_pkg::ADDR_W-1:0];
  endfunction

  // Input unpacking
  logic                       in_acc;
  psf_pkg::action_e           in_act;
  logic [CW-1:0]              in_x, in_z;
  logic [psf_pkg::STEP_W-1:0] in_step;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_act  = psf_pkg::action_e'(s_axis_tuser);
  assign in_x    = s_axis_tdata[CW-1:0];
  assign in_z    = s_axis_tdata[2*CW-1:CW];
  assign in_step = s_axis_tdata[2*CW+psf_pkg::STEP_W-1:2*CW];

  // Repulsion checks
  logic [psf_pkg::DIFF_W-1:0] rep_ext;
  logic                       set_close, fin_close;
  logic [CW-1:0]              fin_x, fin_z;
  logic [psf_pkg::DIFF_W-1:0] oz_rnd;
  logic [psf_pkg::DIFF_W:0]   offx, offz;
  logic                       rnd_up;

  assign rep_ext   = psf_pkg::DIFF_W'(rep_q);
  assign set_close = (psf_pkg::mag(psf_pkg::cdiff(rd_x, in_x_q)) <= rep_ext) &&
                     (psf_pkg::mag(psf_pkg::cdiff(rd_z, in_z_q)) <= rep_ext);

  // Round half up on the divider remainder
  assign rnd_up = {div_rem_q, 1'b0} >= {1'b0, len_q};
  assign oz_rnd = div_quo_q + psf_pkg::DIFF_W'(rnd_up);

  // Interpolated point
  assign offx  = negx_q ? -{1'b0, ox_q} : {1'b0, ox_q};
  assign offz  = negz_q ? -{1'b0, oz_rnd} : {1'b0, oz_rnd};
  assign fin_x = CW'({{2{ax_q[CW-1]}}, ax_q} + offx);
  assign fin_z = CW'({{2{az_q[CW-1]}}, az_q} + offz);
  assign fin_close = (psf_pkg::mag(psf_pkg::cdiff(bx_q, fin_x)) <= rep_ext) &&
                     (psf_pkg::mag(psf_pkg::cdiff(bz_q, fin_z)) <= rep_ext);

  // Segment walk arithmetic
  logic signed [psf_pkg::DIFF_W-1:0] dx, dz;
  logic [psf_pkg::SQ_W-1:0]          sq_trial;
  logic [psf_pkg::TOT_W-1:0]         len_sum;
  logic                              lands;
  logic [psf_pkg::CNT_W-1:0]         seg_next, seg_next2;
  logic [psf_pkg::LEN_W:0]           div_sh;
  logic                              div_ge;
  logic                              iter_last_sqrt, iter_last_div;

  assign dx       = psf_pkg::cdiff(bx_q, ax_q);
  assign dz       = psf_pkg::cdiff(bz_q, az_q);
  assign sq_trial = sq_res_q + sq_bit_q;
  assign len_sum  = total_q + psf_pkg::TOT_W'(len_q);
  assign lands    = (psf_pkg::TOT_W'(step_q) <= len_sum) && (len_q != '0);
  assign seg_next  = seg_q + psf_pkg::CNT_W'(1);
  assign seg_next2 = seg_q + psf_pkg::CNT_W'(2);
  assign div_sh   = {div_rem_q, div_n_q[psf_pkg::PROD_W-1]};
  assign div_ge   = div_sh >= {1'b0, len_q};
  assign iter_last_sqrt = (iter_q == psf_pkg::ITER_W'(psf_pkg::SQRT_STEPS - 1));
  assign iter_last_div  = (iter_q == psf_pkg::ITER_W'(psf_pkg::DIV_STEPS - 1));

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // Memory access decode
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_wdata = {in_z, in_x};
    mem_raddr = head_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_act == psf_pkg::ACT_APPEND &&
            count_q != psf_pkg::CNT_W'(psf_pkg::MAX_POINTS)) begin
          mem_we    = 1'b1;
          mem_waddr = slot(head_q, count_q);
        end else if (in_acc && in_act == psf_pkg::ACT_SET &&
                     count_q == psf_pkg::CNT_W'(1)) begin
          mem_we = 1'b1;
        end
        if (in_act == psf_pkg::ACT_SET) begin
          mem_raddr = slot(head_q, psf_pkg::CNT_W'(1));
        end
      end
      S_SETCMP: begin
        mem_we    = !set_close;
        mem_wdata = {in_z_q, in_x_q};
      end
      S_LDA: mem_raddr = slot(head_q, seg_next);
      S_CHK: mem_raddr = slot(head_q, seg_next2);
      S_FIN: begin
        mem_we    = !fin_close;
        mem_waddr = slot(head_q, seg_q);
        mem_wdata = {fin_z, fin_x};
      end
      default: ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DONE;
          if (in_act == psf_pkg::ACT_SET && count_q > psf_pkg::CNT_W'(1)) begin
            state_d = S_SETCMP;
          end else if (in_act == psf_pkg::ACT_ADVANCE && in_step != '0 &&
                       count_q != '0) begin
            state_d = (count_q == psf_pkg::CNT_W'(1)) ? S_SINGLE : S_LDA;
          end
        end
      end
      S_SETCMP: state_d = S_DONE;
      S_SINGLE: state_d = S_DONE;
      S_LDA:    state_d = S_LDB;
      S_LDB:    state_d = S_DIFF;
      S_DIFF:   state_d = S_SQX;
      S_SQX:    state_d = S_SQZ;
      S_SQZ:    state_d = S_SQRT;
      S_SQRT:   if (iter_last_sqrt) state_d = S_CHK;
      S_CHK: begin
        if (lands) begin
          state_d = S_MULX;
        end else if (seg_next2 < count_q) begin
          state_d = S_LDB;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MULX:   state_d = S_DIVX;
      S_DIVX:   if (iter_last_div) state_d = S_MULZ;
      S_MULZ:   state_d = S_DIVZ;
      S_DIVZ:   if (iter_last_div) state_d = S_FIN;
      S_FIN:    state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      seg_q     <= '0;
      iter_q    <= '0;
      rep_q     <= psf_pkg::REP_W'(256);
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && paddr[2] == psf_pkg::REG_REPULSION) begin
        rep_q <= pwdata[psf_pkg::REP_W-1:0];
      end
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          seg_q <= '0;
          if (in_acc) begin
            if (in_act == psf_pkg::ACT_CLEAR) begin
              head_q  <= '0;
              count_q <= '0;
            end else if (in_act == psf_pkg::ACT_APPEND &&
                         count_q != psf_pkg::CNT_W'(psf_pkg::MAX_POINTS)) begin
              count_q <= count_q + psf_pkg::CNT_W'(1);
            end
          end
        end
        S_SETCMP: begin
          if (set_close) begin
            head_q  <= slot(head_q, psf_pkg::CNT_W'(1));
            count_q <= count_q - psf_pkg::CNT_W'(1);
          end
        end
        S_SQZ:  iter_q <= '0;
        S_SQRT: iter_q <= iter_q + psf_pkg::ITER_W'(1);
        S_CHK: begin
          if (!lands) begin
            seg_q <= seg_next;
            if (seg_next2 >= count_q) begin
              head_q  <= slot(head_q, seg_next);
              count_q <= psf_pkg::CNT_W'(1);
            end
          end
        end
        S_MULX, S_MULZ: iter_q <= '0;
        S_DIVX, S_DIVZ: iter_q <= iter_q + psf_pkg::ITER_W'(1);
        S_FIN: begin
          if (fin_close) begin
            head_q  <= slot(head_q, seg_next);
            count_q <= count_q - seg_next;
          end else begin
            head_q  <= slot(head_q, seg_q);
            count_q <= count_q - seg_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      m_data_q <= {count_q, res_moved_q, res_z_q, res_x_q};
      m_user_q <= res_status_q;
    end
    unique case (state_q)
      S_IDLE: begin
        in_x_q      <= in_x;
        in_z_q      <= in_z;
        step_q      <= in_step;
        total_q     <= '0;
        res_x_q     <= '0;
        res_z_q     <= '0;
        res_moved_q <= '0;
        unique case (in_act)
          psf_pkg::ACT_APPEND:
            res_status_q <= (count_q == psf_pkg::CNT_W'(psf_pkg::MAX_POINTS)) ?
                            psf_pkg::STS_LIST_FULL : psf_pkg::STS_DONE;
          psf_pkg::ACT_SET:
            res_status_q <= (count_q == '0) ? psf_pkg::STS_EMPTY_SET : psf_pkg::STS_DONE;
          psf_pkg::ACT_ADVANCE:
            res_status_q <= (in_step == '0 || count_q == '0) ?
                            psf_pkg::STS_NO_MOVE : psf_pkg::STS_DONE;
          default: res_status_q <= psf_pkg::STS_DONE;
        endcase
      end
      S_SINGLE: begin
        res_x_q      <= rd_x;
        res_z_q      <= rd_z;
        res_status_q <= psf_pkg::STS_SINGLE;
      end
      S_LDA: begin
        ax_q <= rd_x;
        az_q <= rd_z;
      end
      S_LDB: begin
        bx_q <= rd_x;
        bz_q <= rd_z;
      end
      S_DIFF: begin
        magx_q <= psf_pkg::mag(dx);
        magz_q <= psf_pkg::mag(dz);
        negx_q <= dx[psf_pkg::DIFF_W-1];
        negz_q <= dz[psf_pkg::DIFF_W-1];
      end
      S_SQX: sq_q <= magx_q * magx_q;
      S_SQZ: begin
        sq_n_q   <= sq_q + magz_q * magz_q;
        sq_res_q <= '0;
        sq_bit_q <= psf_pkg::SQ_W'(1) << (psf_pkg::SQ_W - 2);
      end
      S_SQRT: begin
        // One root bit per cycle
        if (sq_n_q >= sq_trial) begin
          sq_n_q   <= sq_n_q - sq_trial;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
        if (iter_last_sqrt) begin
          len_q <= (sq_n_q >= sq_trial) ?
                   psf_pkg::LEN_W'((sq_res_q >> 1) + sq_bit_q) :
                   psf_pkg::LEN_W'(sq_res_q >> 1);
        end
      end
      S_CHK: begin
        if (lands) begin
          r_q <= step_q - total_q[psf_pkg::STEP_W-1:0];
        end else begin
          total_q <= len_sum;
          ax_q    <= bx_q;
          az_q    <= bz_q;
          if (seg_next2 >= count_q) begin
            // Ran past the end: keep the last waypoint
            res_x_q      <= bx_q;
            res_z_q      <= bz_q;
            res_moved_q  <= (len_sum > psf_pkg::TOT_W'(psf_pkg::MOVED_MAX)) ?
                            psf_pkg::MOVED_MAX : len_sum[psf_pkg::MOVED_W-1:0];
            res_status_q <= psf_pkg::STS_END;
          end
        end
      end
      S_MULX, S_MULZ: begin
        div_n_q   <= (state_q == S_MULX) ? magx_q * r_q : magz_q * r_q;
        div_rem_q <= '0;
        div_quo_q <= '0;
        if (state_q == S_MULZ) ox_q <= oz_rnd;
      end
      S_DIVX, S_DIVZ: begin
        // Restoring division, one quotient bit per cycle
        div_n_q   <= div_n_q << 1;
        div_rem_q <= div_ge ? psf_pkg::LEN_W'(div_sh - {1'b0, len_q}) :
                              psf_pkg::LEN_W'(div_sh);
        div_quo_q <= {div_quo_q[psf_pkg::DIFF_W-2:0], div_ge};
      end
      S_FIN: begin
        res_x_q      <= fin_x;
        res_z_q      <= fin_z;
        res_moved_q  <= psf_pkg::MOVED_W'(step_q);
        res_status_q <= psf_pkg::STS_FULL_STEP;
      end
      default: ;
    endcase
  end

  // Output and configuration ports
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == psf_pkg::REG_REPULSION) ?
                         32'(rep_q) : 32'd0;

  // Checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= psf_pkg::CNT_W'(psf_pkg::MAX_POINTS)) else $error("list overflow");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVX || state_q == S_DIVZ) |-> len_q != '0)
    else $error("divide by zero length");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE) else $error("request dropped");

  a_walk_has_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LDA) |-> count_q > psf_pkg::CNT_W'(1))
    else $error("walk with fewer than two waypoints");

endmodule

// File: dv/tb_polyline_step_follower.sv
// Self-checking testbench for the polyline step follower: directed and random stream traffic, scoreboard.
module tb_polyline_step_follower;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    psf_pkg::action_e   act;
    logic signed [23:0] px;
    logic signed [23:0] pz;
    logic [22:0]        step;
  } request_t;

  typedef struct {
    logic [23:0]      px;
    logic [23:0]      pz;
    logic [30:0]      moved;
    psf_pkg::status_e sts;
    logic [8:0]       left;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // point_x, point_z, step_length, pad
  logic [1:0]  s_axis_tuser = '0;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;        // pos_x, pos_z, moved, points_left
  logic [2:0]  m_axis_tuser;        // status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  polyline_step_follower u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: waypoint ring, head, count, repulsion distance
  longint      ring_x [psf_pkg::MAX_POINTS];
  longint      ring_z [psf_pkg::MAX_POINTS];
  int          head_pos;
  int          n_points;
  longint      repulse = 256;

  request_t    pending_reqs[$];
  answer_t     expected_answers[$];
  request_t    cur_req;
  int          send_gap;
  int          recv_gap;
  bit          idle_on = 1'b1;
  int          mismatches;

  function automatic longint floor_sqrt(longint n);
    longint res, t;
    res = 0;
    for (int b = 27; b >= 0; b--) begin
      t = res | (longint'(1) << b);
      if (t * t <= n) res = t;
    end
    return res;
  endfunction

  function automatic longint scale_round(longint a, longint r, longint d);
    longint q, rm;
    q  = (a * r) / d;
    rm = (a * r) % d;
    if (2 * rm >= d) q++;
    return q;
  endfunction

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Signed offset of the interpolated point along one axis
  function automatic longint axis_offset(longint d, longint r, longint len);
    return d < 0 ? -scale_round(-d, r, len) : scale_round(d, r, len);
  endfunction

  // Move the current position, dropping the head when the next waypoint is close
  function automatic void place_head(longint px, longint pz);
    int s1;
    s1 = (head_pos + 1) % psf_pkg::MAX_POINTS;
    if (n_points > 1 && absval(ring_x[s1] - px) <= repulse &&
        absval(ring_z[s1] - pz) <= repulse) begin
      head_pos = s1;
      n_points--;
    end else begin
      ring_x[head_pos] = px;
      ring_z[head_pos] = pz;
    end
  endfunction

  // Apply one accepted request and queue the answer it should produce
  function automatic void follow_request(request_t rq);
    answer_t ans;
    longint  rx, rz, moved, total, dx, dz, len, r;
    int      sa, sb, last;
    bit      landed;
    rx = 0; rz = 0; moved = 0;
    ans.sts = psf_pkg::STS_DONE;
    case (rq.act)
      psf_pkg::ACT_CLEAR: begin
        head_pos = 0;
        n_points = 0;
      end
      psf_pkg::ACT_APPEND: begin
        if (n_points >= psf_pkg::MAX_POINTS) ans.sts = psf_pkg::STS_LIST_FULL;
        else begin
          ring_x[(head_pos + n_points) % psf_pkg::MAX_POINTS] = rq.px;
          ring_z[(head_pos + n_points) % psf_pkg::MAX_POINTS] = rq.pz;
          n_points++;
        end
      end
      psf_pkg::ACT_SET: begin
        if (n_points == 0) ans.sts = psf_pkg::STS_EMPTY_SET;
        else place_head(rq.px, rq.pz);
      end
      default: begin
        if (rq.step == 0 || n_points == 0) ans.sts = psf_pkg::STS_NO_MOVE;
        else if (n_points == 1) begin
          rx = ring_x[head_pos];
          rz = ring_z[head_pos];
          ans.sts = psf_pkg::STS_SINGLE;
        end else begin
          total = 0;
          landed = 1'b0;
          for (int i = 0; i + 1 < n_points && !landed; i++) begin
            sa  = (head_pos + i) % psf_pkg::MAX_POINTS;
            sb  = (head_pos + i + 1) % psf_pkg::MAX_POINTS;
            dx  = ring_x[sb] - ring_x[sa];
            dz  = ring_z[sb] - ring_z[sa];
            len = floor_sqrt(dx * dx + dz * dz);
            if (rq.step <= len + total && len > 0) begin
              r  = rq.step - total;
              rx = ring_x[sa] + axis_offset(dx, r, len);
              rz = ring_z[sa] + axis_offset(dz, r, len);
              head_pos = sa;
              n_points -= i;
              place_head(rx, rz);
              moved = rq.step;
              ans.sts = psf_pkg::STS_FULL_STEP;
              landed = 1'b1;
            end else total += len;
          end
          if (!landed) begin
            last = (head_pos + n_points - 1) % psf_pkg::MAX_POINTS;
            head_pos = last;
            n_points = 1;
            rx = ring_x[last];
            rz = ring_z[last];
            moved = total > longint'(psf_pkg::MOVED_MAX) ?
                    longint'(psf_pkg::MOVED_MAX) : total;
            ans.sts = psf_pkg::STS_END;
          end
        end
      end
    endcase
    ans.px    = rx[23:0];
    ans.pz    = rz[23:0];
    ans.moved = moved[30:0];
    ans.left  = n_points[8:0];
    expected_answers.insert(expected_answers.size(), ans);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: present queued requests, predict on every accepted one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) follow_request(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tdata  <= {1'b0, cur_req.step, cur_req.pz, cur_req.px};
          s_axis_tuser  <= cur_req.act;
          s_axis_tvalid <= 1'b1;
          send_gap <= pick_gap();
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, compare every accepted result
  always @(posedge clk_i) begin
    answer_t want;
    answer_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.px    = m_axis_tdata[23:0];
        got.pz    = m_axis_tdata[47:24];
        got.moved = m_axis_tdata[78:48];
        got.left  = m_axis_tdata[87:79];
        got.sts   = psf_pkg::status_e'(m_axis_tuser);
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: status %0d", got.sts);
        end else begin
          want = expected_answers.pop_front();
          if (got.px !== want.px || got.pz !== want.pz || got.moved !== want.moved ||
              got.sts !== want.sts || got.left !== want.left) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp x=%h z=%h moved=%0d sts=%0d left=%0d",
                        " | got x=%h z=%h moved=%0d sts=%0d left=%0d"},
                       want.px, want.pz, want.moved, want.sts, want.left,
                       got.px, got.pz, got.moved, got.sts, got.left);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  task automatic push_req(psf_pkg::action_e a, longint x, longint z, longint s);
    request_t rq;
    rq.act = a; rq.px = x[23:0]; rq.pz = z[23:0]; rq.step = s[22:0];
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  function automatic longint rand_coord(bit near);
    if (near) return longint'($urandom_range(0, 4095)) - 2048;
    return longint'($signed(24'($urandom)));
  endfunction

  function automatic longint rand_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 50) return $urandom_range(1, 1024);
    if (r < 80) return $urandom_range(1, 65535);
    return $urandom_range(0, 8388607);
  endfunction

  // Fill the queue with about n requests of mostly well-formed path traffic
  task automatic queue_random(int n, bit fill_once);
    int  added, k;
    bit  near;
    added = 0;
    if (fill_once) begin
      push_req(psf_pkg::ACT_CLEAR, 0, 0, 0);
      for (int i = 0; i < psf_pkg::MAX_POINTS + 2; i++)
        push_req(psf_pkg::ACT_APPEND, rand_coord(1), rand_coord(1), 0);
      for (int i = 0; i < 6; i++) push_req(psf_pkg::ACT_ADVANCE, 0, 0, rand_step());
      push_req(psf_pkg::ACT_ADVANCE, 0, 0, 8388607);
      added += psf_pkg::MAX_POINTS + 10;
    end
    while (added < n) begin
      if ($urandom_range(0, 9) == 0) begin
        push_req(psf_pkg::action_e'($urandom_range(0, 3)), rand_coord(0), rand_coord(0),
                 $urandom);
        added++;
      end else begin
        near = $urandom_range(0, 2) != 0;
        push_req(psf_pkg::ACT_CLEAR, 0, 0, 0);
        k = $urandom_range(0, 4) == 0 ? $urandom_range(9, 30) : $urandom_range(1, 8);
        for (int i = 0; i < k; i++)
          push_req(psf_pkg::ACT_APPEND, rand_coord(near), rand_coord(near), 0);
        added += k + 1;
        for (int i = $urandom_range(1, 8); i > 0; i--) begin
          if ($urandom_range(0, 3) == 0)
            push_req(psf_pkg::ACT_SET, rand_coord(near), rand_coord(near), 0);
          else if ($urandom_range(0, 4) == 0)
            push_req(psf_pkg::ACT_APPEND, rand_coord(near), rand_coord(near), 0);
          else push_req(psf_pkg::ACT_ADVANCE, 0, 0, rand_step());
          added++;
        end
      end
    end
  endtask

  task automatic write_repulsion(logic [22:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(psf_pkg::REG_REPULSION) << 2; pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    repulse = value;
  endtask

  // Hold the sender until everything queued is through and answered
  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    logic [22:0] rep_vals[6];
    rep_vals = '{23'd0, 23'd8388607, 23'd256, 23'd4, 23'd1024, 23'd0};
    rep_vals[3] = 23'($urandom_range(0, 8388607));
    head_pos = 0;
    n_points = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list cases, single point, extremes, drop on set
    push_req(psf_pkg::ACT_ADVANCE, 0, 0, 100);
    push_req(psf_pkg::ACT_SET, 5, 5, 0);
    push_req(psf_pkg::ACT_APPEND, 100, -100, 0);
    push_req(psf_pkg::ACT_ADVANCE, 0, 0, 50);
    push_req(psf_pkg::ACT_SET, 300, 400, 0);
    push_req(psf_pkg::ACT_ADVANCE, 0, 0, 0);
    push_req(psf_pkg::ACT_APPEND, -8388608, 8388607, 0);
    push_req(psf_pkg::ACT_APPEND, 8388607, -8388608, 0);
    push_req(psf_pkg::ACT_ADVANCE, 0, 0, 1000);
    push_req(psf_pkg::ACT_ADVANCE, 0, 0, 8388607);
    push_req(psf_pkg::ACT_ADVANCE, 0, 0, 8388607);
    push_req(psf_pkg::ACT_CLEAR, 0, 0, 0);
    push_req(psf_pkg::ACT_APPEND, 0, 0, 0);
    push_req(psf_pkg::ACT_APPEND, 1000, 0, 0);
    push_req(psf_pkg::ACT_APPEND, 1000, 1000, 0);
    push_req(psf_pkg::ACT_SET, 900, 100, 0);
    push_req(psf_pkg::ACT_SET, 500, 0, 0);
    push_req(psf_pkg::ACT_ADVANCE, 0, 0, 700);
    push_req(psf_pkg::ACT_ADVANCE, 0, 0, 3);
    push_req(psf_pkg::ACT_CLEAR, 0, 0, 0);
    drain();

    // Random phases, each with a repulsion distance written first and idling on except in phase 2
    for (int ph = 0; ph < 6; ph++) begin
      write_repulsion(rep_vals[ph]);
      idle_on = ph != 2;
      queue_random(260, ph == 1 || ph == 4);
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (mismatches == 0) $display("tb_polyline_step_follower: done, clean");
    else $display("tb_polyline_step_follower: done, errors");
    $finish;
  end

  // Run limit
  initial begin
    #60ms;
    $display("tb_polyline_step_follower: done, errors");
    $finish;
  end

endmodule

// File: files.f
design/psf_pkg.sv
design/psf_ram.sv
design/polyline_step_follower.sv
dv/tb_polyline_step_follower.sv
